FILE: hw/rtl/cds_pkg.sv
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types, codes and calendar helpers for the date stepper.
// ----------------------------------------------------------------------------
package cds_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CountW = 16;

  localparam int unsigned MaxYearDef = 9999;
  localparam logic [YearW-1:0] ResetYear = YearW'(2000);

  typedef enum logic [1:0] {
    KIND_SET = 2'd0,
    KIND_ADD = 2'd1,
    KIND_SUB = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FIXED = 2'd1,
    STAT_SAT   = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk;   // accepted item needs the step loop
    logic fin;    // step loop finishes this cycle
  } dp_stat_t;

  // Leap test: divisible by 4, and not by 100 unless by 400.
  // Divisibility by 25 uses a reciprocal multiply (exact for 14-bit years).
  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [28:0] prod;
    logic [9:0]  q;
    logic [14:0] back;
    logic        div25;
    prod  = {15'd0, y} * 29'd20972;
    q     = prod[28:19];
    back  = {1'b0, q, 4'd0} + {2'b0, q, 3'd0} + {5'd0, q};
    div25 = (back == {1'b0, y});
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] m,
                                                   input logic leap);
    logic [DayW-1:0] len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: hw/rtl/cds_in_if.sv
// ----------------------------------------------------------------------------
// cds_in_if
// Input channel: command item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cds_in_if;
  import cds_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [DayW-1:0]   new_day;
  logic [MonthW-1:0] new_month;
  logic [YearW-1:0]  new_year;
  logic [CountW-1:0] day_count;

  modport source (output valid, kind, new_day, new_month, new_year, day_count,
                  input ready);
  modport sink   (input valid, kind, new_day, new_month, new_year, day_count,
                  output ready);
endinterface

FILE: hw/rtl/cds_out_if.sv
// ----------------------------------------------------------------------------
// cds_out_if
// Output channel: resulting date item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cds_out_if;
  import cds_pkg::*;

  logic              valid;
  logic              ready;
  logic [DayW-1:0]   cur_day;
  logic [MonthW-1:0] cur_month;
  logic [YearW-1:0]  cur_year;
  logic              leap_flag;
  logic [1:0]        status;

  modport source (output valid, cur_day, cur_month, cur_year, leap_flag, status,
                  input ready);
  modport sink   (input valid, cur_day, cur_month, cur_year, leap_flag, status,
                  output ready);
endinterface

FILE: hw/rtl/calendar_date_day_stepper.sv
// ----------------------------------------------------------------------------
// calendar_date_day_stepper
// Gregorian date register with set, add-days and remove-days items.
// ----------------------------------------------------------------------------
// One item is in work at a time. A set item, or a kind with no meaning,
// skips the step unit and goes straight to the emit state, where it is
// written into the output register once that register is free. An add
// or remove item first walks the date through the step unit: whole-year
// skips (taken only on 1 January forward or 31 December backward), one
// step per month boundary crossed, and a final step within the month;
// a count of 65535 needs about 180 year skips and up to two dozen month
// steps. Past 31 December of MAX_YEAR or before 1 January of year 1 the date
// saturates with status 2. The output register lets a new item be accepted
// while the previous result is still waiting to be taken.
// ----------------------------------------------------------------------------
module calendar_date_day_stepper #(
  parameter int unsigned MAX_YEAR = cds_pkg::MaxYearDef
) (
  input logic       clk,
  input logic       rst,
  cds_in_if.sink    in_ch,
  cds_out_if.source out_ch
);
  import cds_pkg::*;

  cmd_t     cmd;
  dp_stat_t dp_stat;

  cds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .dp_stat   (dp_stat),
    .cmd       (cmd)
  );

  cds_dp #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .dp_stat   (dp_stat),
    .kind      (in_ch.kind),
    .new_day   (in_ch.new_day),
    .new_month (in_ch.new_month),
    .new_year  (in_ch.new_year),
    .day_count (in_ch.day_count),
    .cur_day   (out_ch.cur_day),
    .cur_month (out_ch.cur_month),
    .cur_year  (out_ch.cur_year),
    .leap_flag (out_ch.leap_flag),
    .status    (out_ch.status)
  );

endmodule

FILE: hw/rtl/cds_ctrl.sv
// ----------------------------------------------------------------------------
// cds_ctrl
// Sequencer: accepts an item, runs the step loop for add and remove items,
// hands the result out.
module cds_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  cds_pkg::dp_stat_t dp_stat,
  output cds_pkg::cmd_t     cmd
);
  import cds_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = dp_stat.walk ? S_STEP : S_EMIT;
        end
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (dp_stat.fin) state_next = S_EMIT;
      end
      S_EMIT: begin
        // output register is free or being drained this cycle
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: hw/rtl/cds_dp.sv
// ----------------------------------------------------------------------------
// cds_dp
// Date registers, set correction, year/month step unit and result register.
// ----------------------------------------------------------------------------
module cds_dp #(
  parameter int unsigned MAX_YEAR = cds_pkg::MaxYearDef
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cds_pkg::cmd_t             cmd,
  output cds_pkg::dp_stat_t         dp_stat,
  input  logic [1:0]                kind,
  input  logic [cds_pkg::DayW-1:0]   new_day,
  input  logic [cds_pkg::MonthW-1:0] new_month,
  input  logic [cds_pkg::YearW-1:0]  new_year,
  input  logic [cds_pkg::CountW-1:0] day_count,
  output logic [cds_pkg::DayW-1:0]   cur_day,
  output logic [cds_pkg::MonthW-1:0] cur_month,
  output logic [cds_pkg::YearW-1:0]  cur_year,
  output logic                      leap_flag,
  output logic [1:0]                status
);
  import cds_pkg::*;

  localparam logic [YearW-1:0] YearMax = YearW'(MAX_YEAR);

  logic [DayW-1:0]   day, day_next;
  logic [MonthW-1:0] month, month_next;
  logic [YearW-1:0]  year, year_next;
  logic [CountW-1:0] rem, rem_next;
  logic              back;     // 1: moving toward earlier dates
  logic [1:0]        stat, stat_next;

  // set correction
  logic [YearW-1:0]  set_year;
  logic [MonthW-1:0] set_month;
  logic [DayW-1:0]   set_day;
  logic              set_fix;

  // step unit
  logic              leap_cur;
  logic [DayW-1:0]   mlen;
  logic [DayW-1:0]   prev_len;
  logic [8:0]        ylen;
  logic [DayW-1:0]   left;
  logic              fin;

  always_comb begin
    set_fix   = 1'b0;
    set_year  = new_year;
    set_month = new_month;
    set_day   = new_day;
    if (new_year == '0) begin
      set_year = ResetYear;
      set_fix  = 1'b1;
    end else if (new_year > YearMax) begin
      set_year = YearMax;
      set_fix  = 1'b1;
    end
    if (new_month == '0 || new_month > 4'd12) begin
      set_month = 4'd1;
      set_fix   = 1'b1;
    end
    if (new_day == '0 || new_day > month_length(set_month, is_leap(set_year))) begin
      set_day = 5'd1;
      set_fix = 1'b1;
    end
  end

  assign leap_cur = is_leap(year);
  assign mlen     = month_length(month, leap_cur);
  assign prev_len = (month == 4'd1) ? 5'd31 : month_length(month - 4'd1, leap_cur);
  assign ylen     = leap_cur ? 9'd366 : 9'd365;
  assign left     = mlen - day;

  // One year skip, one month step or the final in-month step per cycle, with saturation at the year limits.
  always_comb begin
    day_next   = day;
    month_next = month;
    year_next  = year;
    rem_next   = rem;
    stat_next  = stat;
    fin        = 1'b0;
    if (!back) begin
      if (day == 5'd1 && month == 4'd1 && rem >= {7'd0, ylen}) begin
        if (year == YearMax) begin
          day_next   = 5'd31;
          month_next = 4'd12;
          stat_next  = STAT_SAT;
          fin        = 1'b1;
        end else begin
          year_next = year + 1'b1;
          rem_next  = rem - {7'd0, ylen};
        end
      end else if (rem <= {11'd0, left}) begin
        day_next = day + rem[DayW-1:0];
        fin      = 1'b1;
      end else if (month == 4'd12 && year == YearMax) begin
        day_next  = 5'd31;
        stat_next = STAT_SAT;
        fin       = 1'b1;
      end else begin
        rem_next = rem - ({11'd0, left} + 16'd1);
        day_next = 5'd1;
        if (month == 4'd12) begin
          month_next = 4'd1;
          year_next  = year + 1'b1;
        end else begin
          month_next = month + 4'd1;
        end
      end
    end else begin
      if (day == 5'd31 && month == 4'd12 && rem >= {7'd0, ylen}) begin
        if (year == YearW'(1)) begin
          day_next   = 5'd1;
          month_next = 4'd1;
          stat_next  = STAT_SAT;
          fin        = 1'b1;
        end else begin
          year_next = year - 1'b1;
          rem_next  = rem - {7'd0, ylen};
        end
      end else if (rem < {11'd0, day}) begin
        day_next = day - rem[DayW-1:0];
        fin      = 1'b1;
      end else if (month == 4'd1 && year == YearW'(1)) begin
        day_next  = 5'd1;
        stat_next = STAT_SAT;
        fin       = 1'b1;
      end else begin
        rem_next = rem - {11'd0, day};
        day_next = prev_len;
        if (month == 4'd1) begin
          month_next = 4'd12;
          year_next  = year - 1'b1;
        end else begin
          month_next = month - 4'd1;
        end
      end
    end
  end

  assign dp_stat.walk = (kind == KIND_ADD) || (kind == KIND_SUB);
  assign dp_stat.fin  = fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      day   <= 5'd1;
      month <= 4'd1;
      year  <= ResetYear;
    end else if (cmd.load) begin
      if (kind == KIND_SET) begin
        day   <= set_day;
        month <= set_month;
        year  <= set_year;
      end
    end else if (cmd.step) begin
      day   <= day_next;
      month <= month_next;
      year  <= year_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem  <= day_count;
      back <= (kind == KIND_SUB);
      stat <= (kind == KIND_SET && set_fix) ? STAT_FIXED : STAT_OK;
    end else if (cmd.step) begin
      rem  <= rem_next;
      stat <= stat_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cur_day   <= day;
      cur_month <= month;
      cur_year  <= year;
      leap_flag <= leap_cur;
      status    <= stat;
    end
  end

endmodule
